// ===== sv/indexed_linked_list_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Linked list engine assertion macros
// Shared assertion forms for the linked list engine.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LINKED_LIST_ENGINE_MACROS_SVH

// Asserts that a property holds on every clock edge outside reset.
`define ILL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Asserts a property that holds on every clock edge, reset included.
`define ILL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/ill_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked list engine package
// Types and constants of the linked list engine.
// ----------------------------------------------------------------------------
package ill_pkg;

   localparam int CAPACITY   = 64;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int PTR_W      = SLOT_W + 1;
   localparam int WORD_WIDTH = 32;
   localparam int IO_WIDTH   = 32;
   localparam int FUNC_W     = 3;
   localparam int POS_W      = 7;
   localparam int LEN_W      = 7;
   localparam int STATUS_W   = 2;

   localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND       = 3'd0,
      FN_PREPEND      = 3'd1,
      FN_INSERT_AT    = 3'd2,
      FN_READ_AT      = 3'd3,
      FN_OVERWRITE_AT = 3'd4,
      FN_REMOVE_AT    = 3'd5,
      FN_REMOVE_LAST  = 3'd6,
      FN_REMOVE_FIRST = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_WALK,
      S_WAIT,
      S_STEP,
      S_POP,
      S_POP_WAIT,
      S_LINK,
      S_VREAD,
      S_VWAIT,
      S_UNLINK,
      S_DONE
   } state_type;

endpackage

// ===== sv/indexed_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// Indexed linked list engine
// A bounded singly linked list of signed words held in slot memories.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until the single result word is shown on the rsp_ ports for one cycle with
// done high, and the receiver must take it then. Indexed, append and
// remove-last commands walk the next-pointer memory one link at a time,
// each link taking an address, a registered read and a step. After reset
// the free-slot stack is filled by a pass over all 64 slots during which
// busy is high.
`include "indexed_linked_list_engine_macros.svh"

module indexed_linked_list_engine
   import ill_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   output logic                       done,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [IO_WIDTH-1:0] req_data_word,
   output logic signed [IO_WIDTH-1:0] rsp_read_word,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [LEN_W-1:0]           rsp_length
);

   logic [WORD_WIDTH-1:0] value_mem [CAPACITY];
   logic [PTR_W-1:0]      link_mem  [CAPACITY];
   logic [SLOT_W-1:0]     free_mem  [CAPACITY];

   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      ftop_ff, ftop_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   func_type              func_ff, func_in;
   logic [LEN_W-1:0]      target_ff, target_in;
   logic [LEN_W-1:0]      steps_ff, steps_in;
   logic [WORD_WIDTH-1:0] data_ff, data_in;
   logic [PTR_W-1:0]      cur_ff, cur_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [IO_WIDTH-1:0]   rword_ff, rword_in;
   logic                  done_ff, done_in;

   logic [PTR_W-1:0]      link_rd_ff;
   logic [WORD_WIDTH-1:0] value_rd_ff;
   logic [SLOT_W-1:0]     free_rd_ff;
   logic                  link_we, value_we, free_we;
   logic [SLOT_W-1:0]     link_wa, value_wa, free_wa, link_ra, value_ra, free_ra;
   logic [PTR_W-1:0]      link_wd;
   logic [SLOT_W-1:0]     free_wd;

   logic                  is_insert, is_access;
   logic [LEN_W-1:0]      req_pos_len;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (value_we) begin
         value_mem[value_wa] <= data_ff;
      end
      if (free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      link_rd_ff  <= link_mem[link_ra];
      value_rd_ff <= value_mem[value_ra];
      free_rd_ff  <= free_mem[free_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_ff  <= NIL_PTR;
         ftop_ff  <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         ftop_ff  <= ftop_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      func_ff   <= func_in;
      target_ff <= target_in;
      steps_ff  <= steps_in;
      data_ff   <= data_in;
      cur_ff    <= cur_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      rword_ff  <= rword_in;
   end

   assign req_pos_len = req_position;
   assign is_insert = (func_ff == FN_APPEND) || (func_ff == FN_PREPEND) ||
                      (func_ff == FN_INSERT_AT);
   assign is_access = (func_ff == FN_READ_AT) || (func_ff == FN_OVERWRITE_AT);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      ftop_in   = ftop_ff;
      count_in  = count_ff;
      func_in   = func_ff;
      target_in = target_ff;
      steps_in  = steps_ff;
      data_in   = data_ff;
      cur_in    = cur_ff;
      slot_in   = slot_ff;
      status_in = status_ff;
      rword_in  = rword_ff;
      done_in   = 1'b0;
      link_we   = 1'b0;
      value_we  = 1'b0;
      free_we   = 1'b0;
      link_wa   = cur_ff[SLOT_W-1:0];
      link_wd   = head_ff;
      value_wa  = slot_ff;
      free_wa   = ftop_ff[SLOT_W-1:0];
      free_wd   = slot_ff;
      link_ra   = cur_ff[SLOT_W-1:0];
      value_ra  = cur_ff[SLOT_W-1:0];
      free_ra   = SLOT_W'(ftop_ff - PTR_W'(1));
      case (state_ff)
         S_INIT: begin
            free_we = 1'b1;
            free_wd = ftop_ff[SLOT_W-1:0];
            ftop_in = ftop_ff + PTR_W'(1);
            if (ftop_ff == NIL_PTR - PTR_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               func_in   = func_type'(req_func);
               data_in   = WORD_WIDTH'(req_data_word);
               rword_in  = '0;
               status_in = ST_OK;
               cur_in    = head_ff;
               steps_in  = '0;
               state_in  = S_DONE;
               case (func_type'(req_func))
                  FN_APPEND, FN_PREPEND, FN_INSERT_AT: begin
                     target_in = (req_func == FN_APPEND) ? count_ff :
                                 (req_func == FN_PREPEND) ? '0 : req_pos_len;
                     if (count_ff == LEN_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (req_func == FN_INSERT_AT && req_pos_len > count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  FN_READ_AT, FN_OVERWRITE_AT, FN_REMOVE_AT: begin
                     target_in = req_pos_len;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (req_pos_len >= count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     target_in = (req_func == FN_REMOVE_LAST) ?
                                 count_ff - LEN_W'(1) : '0;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            state_in = S_POP_WAIT;
         end
         S_POP_WAIT: begin
            slot_in  = free_rd_ff;
            ftop_in  = ftop_ff - PTR_W'(1);
            state_in = S_WALK;
         end
         S_WALK: begin
            // Inserts and removes stop one node short of the target.
            if (is_access) begin
               state_in = (steps_ff == target_ff) ? S_VREAD : S_WAIT;
            end else if (target_ff == '0) begin
               state_in = is_insert ? S_LINK : S_UNLINK;
            end else begin
               state_in = (steps_ff == target_ff - LEN_W'(1)) ?
                          (is_insert ? S_LINK : S_UNLINK) : S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            cur_in   = link_rd_ff;
            steps_in = steps_ff + LEN_W'(1);
            state_in = S_WALK;
         end
         S_LINK: begin
            value_we = 1'b1;
            state_in = S_VWAIT;
            if (target_ff == '0) begin
               link_we  = 1'b1;
               link_wa  = slot_ff;
               link_wd  = head_ff;
               head_in  = PTR_W'(slot_ff);
               count_in = count_ff + LEN_W'(1);
               state_in = S_DONE;
            end
         end
         S_VWAIT: begin
            // Link memory data for the predecessor is ready now.
            link_we  = 1'b1;
            link_wa  = slot_ff;
            link_wd  = link_rd_ff;
            state_in = S_UNLINK;
         end
         S_UNLINK: begin
            if (is_insert) begin
               link_we  = 1'b1;
               link_wa  = cur_ff[SLOT_W-1:0];
               link_wd  = PTR_W'(slot_ff);
               count_in = count_ff + LEN_W'(1);
               state_in = S_DONE;
            end else if (target_ff == '0) begin
               // Removing the front: the victim is the head.
               state_in = S_VWAIT;
               if (steps_ff == '1) begin
                  head_in  = link_rd_ff;
                  free_we  = 1'b1;
                  free_wd  = cur_ff[SLOT_W-1:0];
                  ftop_in  = ftop_ff + PTR_W'(1);
                  count_in = count_ff - LEN_W'(1);
                  state_in = S_DONE;
               end else begin
                  steps_in = '1;
                  state_in = S_UNLINK;
               end
            end else begin
               state_in = S_POP;
               if (steps_ff == '1) begin
                  // The link read holds the victim's slot; read its next link.
                  slot_in  = link_rd_ff[SLOT_W-1:0];
                  link_ra  = link_rd_ff[SLOT_W-1:0];
                  steps_in = '0;
                  state_in = S_VREAD;
               end else begin
                  steps_in = '1;
                  state_in = S_UNLINK;
               end
            end
         end
         S_VREAD: begin
            if (is_access) begin
               state_in = S_VWAIT;
               if (func_ff == FN_OVERWRITE_AT) begin
                  value_we = 1'b1;
                  value_wa = cur_ff[SLOT_W-1:0];
                  state_in = S_DONE;
               end else begin
                  steps_in = '1;
                  state_in = S_STEP;
                  if (steps_ff == '1) begin
                     rword_in = IO_WIDTH'(signed'(value_rd_ff));
                     state_in = S_DONE;
                  end
               end
            end else begin
               link_ra = slot_ff;
               if (steps_ff == '1) begin
                  link_we  = 1'b1;
                  link_wa  = cur_ff[SLOT_W-1:0];
                  link_wd  = link_rd_ff;
                  free_we  = 1'b1;
                  free_wd  = slot_ff;
                  ftop_in  = ftop_ff + PTR_W'(1);
                  count_in = count_ff - LEN_W'(1);
                  state_in = S_DONE;
               end else begin
                  steps_in = '1;
               end
            end
         end
         S_DONE: begin
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Read-value path passes through STEP when reading; fix up here.
      if (state_ff == S_STEP && func_ff == FN_READ_AT && steps_ff == '1 &&
          is_access) begin
         cur_in   = cur_ff;
         steps_in = '1;
         state_in = S_VREAD;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign done          = done_ff;
   assign rsp_read_word = signed'(rword_ff);
   assign rsp_status    = status_ff;
   assign rsp_length    = count_ff;

   `ILL_ASSERT(a_done_pulse, clock, reset, done |=> !done, "done held over two cycles")
   `ILL_ASSERT(a_count_range, clock, reset, count_ff <= LEN_W'(CAPACITY), "count too large")
   `ILL_ASSERT(a_stack_tracks_count, clock, reset,
      (state_ff == S_IDLE) |-> (PTR_W'(count_ff) + ftop_ff == NIL_PTR),
      "free stack and count disagree")
   `ILL_ASSERT(a_empty_head, clock, reset,
      (state_ff == S_IDLE && count_ff == '0) |-> (head_ff == NIL_PTR),
      "empty list with a head")

endmodule

// ===== sim/tb_indexed_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// Linked list engine testbench
// Drives list commands through the start/busy handshake. A scoreboard holds
// a behavioural copy of the list and checks each result word on done.
// ----------------------------------------------------------------------------
module tb_indexed_linked_list_engine
   import ill_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [IO_WIDTH-1:0] read_word;
      logic [STATUS_W-1:0]        status;
      logic [LEN_W-1:0]           length;
   } list_result_type;

   class list_scoreboard;
      logic signed [WORD_WIDTH-1:0] contents[$];
      list_result_type              pending[$];
      int                           mismatches;
      int                           checked;

      function void note_command(func_type fn, int pos, logic signed [31:0] word);
         list_result_type r;
         int n;
         int p;
         n = contents.size();
         r.read_word = '0;
         r.status    = ST_OK;
         case (fn)
            FN_APPEND, FN_PREPEND, FN_INSERT_AT: begin
               p = (fn == FN_APPEND) ? n : (fn == FN_PREPEND) ? 0 : pos;
               if (n >= CAPACITY) r.status = ST_FULL;
               else if (p > n) r.status = ST_RANGE;
               else contents.insert(p, word);
            end
            FN_READ_AT, FN_OVERWRITE_AT, FN_REMOVE_AT: begin
               if (n == 0) r.status = ST_EMPTY;
               else if (pos >= n) r.status = ST_RANGE;
               else if (fn == FN_REMOVE_AT) contents.delete(pos);
               else if (fn == FN_OVERWRITE_AT) contents[pos] = word;
               else r.read_word = contents[pos];
            end
            default: begin
               if (n == 0) r.status = ST_EMPTY;
               else if (fn == FN_REMOVE_LAST) contents.delete(n - 1);
               else contents.delete(0);
            end
         endcase
         r.length = LEN_W'(contents.size());
         pending = {pending, r};
      endfunction

      function void check_result(logic signed [31:0] rd, logic [1:0] st, logic [6:0] len);
         list_result_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word at %0t", $realtime);
            return;
         end
         e = pending.pop_front();
         if (e.read_word !== rd || e.status !== st || e.length !== len) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected rd=%0d st=%0d len=%0d, got rd=%0d st=%0d len=%0d",
                        e.read_word, e.status, e.length, rd, st, len);
         end
      endfunction
   endclass

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       start = 0;
   logic                       busy;
   logic                       done;
   logic [FUNC_W-1:0]          req_func = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic signed [IO_WIDTH-1:0] req_data_word = '0;
   logic signed [IO_WIDTH-1:0] rsp_read_word;
   logic [STATUS_W-1:0]        rsp_status;
   logic [LEN_W-1:0]           rsp_length;

   list_scoreboard board = new();
   int             cycles = 0;
   localparam int  CYCLE_LIMIT = 1500000;

   indexed_linked_list_engine uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .done(done),
      .req_func(req_func), .req_position(req_position), .req_data_word(req_data_word),
      .rsp_read_word(rsp_read_word), .rsp_status(rsp_status), .rsp_length(rsp_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && done) board.check_result(rsp_read_word, rsp_status, rsp_length);
      if (cycles > CYCLE_LIMIT) begin
         $display("Run timed out");
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int gap_length();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      return n;
   endfunction

   task automatic issue_command(func_type fn, int pos, logic signed [31:0] word);
      int n;
      n = gap_length();
      if (n > 0) begin
         start         <= 1'b0;
         req_position  <= POS_W'($urandom);
         req_data_word <= $urandom;
         repeat (n) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= fn;
      req_position  <= POS_W'(pos);
      req_data_word <= word;
      do @(posedge clock); while (busy);
      board.note_command(fn, pos, word);
   endtask

   function automatic int random_position();
      int n;
      n = board.contents.size();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 127);
         1:       return n;
         default: return (n == 0) ? 0 : $urandom_range(0, n - 1);
      endcase
   endfunction

   initial begin
      func_type fn;
      int       fill_bias;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      issue_command(FN_READ_AT, 0, 0);
      issue_command(FN_REMOVE_LAST, 0, 0);
      issue_command(FN_REMOVE_FIRST, 0, 0);
      issue_command(FN_REMOVE_AT, 0, 0);
      issue_command(FN_OVERWRITE_AT, 0, 5);
      issue_command(FN_INSERT_AT, 1, 7);
      issue_command(FN_INSERT_AT, 0, 32'sh7fffffff);
      issue_command(FN_APPEND, 0, 32'sh80000000);
      issue_command(FN_PREPEND, 0, -1);
      issue_command(FN_INSERT_AT, 3, 0);
      issue_command(FN_INSERT_AT, 1, 42);
      issue_command(FN_READ_AT, 4, 0);
      issue_command(FN_READ_AT, 5, 0);
      issue_command(FN_READ_AT, 127, 0);
      issue_command(FN_OVERWRITE_AT, 2, 32'sh55aa55aa);
      issue_command(FN_READ_AT, 2, 0);
      issue_command(FN_REMOVE_AT, 2, 0);
      issue_command(FN_REMOVE_AT, 0, 0);
      issue_command(FN_REMOVE_LAST, 0, 0);
      issue_command(FN_REMOVE_FIRST, 0, 0);
      while (board.contents.size() < CAPACITY) issue_command(FN_APPEND, 0, $urandom);
      issue_command(FN_APPEND, 0, 1);
      issue_command(FN_PREPEND, 0, 1);
      issue_command(FN_INSERT_AT, 10, 1);
      issue_command(FN_READ_AT, 63, 0);
      issue_command(FN_REMOVE_AT, 63, 0);
      fill_bias = 50;
      for (int i = 0; i < 1200; i++) begin
         if (i % 150 == 0) fill_bias = $urandom_range(20, 80);
         if ($urandom_range(0, 99) < fill_bias)
            fn = func_type'($urandom_range(0, 2));
         else
            fn = func_type'($urandom_range(3, 7));
         issue_command(fn, random_position(), $urandom);
      end
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Checked %0d result words over mixed fill levels, errors and full list.",
               board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ===== indexed_linked_list_engine.f =====
+incdir+sv
sv/ill_pkg.sv
sv/indexed_linked_list_engine.sv
sim/tb_indexed_linked_list_engine.sv
